>>> sv/nclt_pkg.sv
`timescale 1ns / 1ps

package nclt_pkg;

    localparam int CACHE_ENTRIES = 16;
    localparam int IDX_W         = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int ID_W          = 32;
    localparam int TAG_W         = 32;
    localparam int SLOT_W        = 4;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_CREATE = 1'b1;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [ID_W-1:0]  t_id;
    typedef logic [TAG_W-1:0] t_tag;

    typedef struct packed {
        logic opcode;
        t_id  node_id;
    } t_in_item;

    typedef struct packed {
        logic              hit;
        logic              evicted;
        t_id               evicted_id;
        logic [SLOT_W-1:0] slot;
    } t_out_item;

    // running outcome of the scan over the entries
    typedef struct packed {
        logic match_found;
        t_idx match_idx;
        logic free_found;
        t_idx free_idx;
        logic vic_found;
        t_idx vic_idx;
        t_tag vic_tag;
        t_id  vic_id;
    } t_scan_res;

endpackage

>>> sv/nclt_store.sv
`timescale 1ns / 1ps

module nclt_store (
    input  logic          i_clk,
    input  logic          i_we,
    input  nclt_pkg::t_idx i_waddr,
    input  nclt_pkg::t_id  i_wid,
    input  nclt_pkg::t_tag i_wtag,
    input  nclt_pkg::t_idx i_raddr,
    output nclt_pkg::t_id  o_rid,
    output nclt_pkg::t_tag o_rtag
);
    import nclt_pkg::*;

    t_id  mem_id  [CACHE_ENTRIES];
    t_tag mem_tag [CACHE_ENTRIES];
    t_id  r_rid;
    t_tag r_rtag;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_id[i_waddr]  <= i_wid;
            mem_tag[i_waddr] <= i_wtag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rid  <= mem_id[i_raddr];
        r_rtag <= mem_tag[i_raddr];
    end

    assign o_rid  = r_rid;
    assign o_rtag = r_rtag;

endmodule

>>> sv/nclt_scan.sv
`timescale 1ns / 1ps

module nclt_scan (
    input  logic               i_clk,
    input  logic               i_clear,
    input  logic               i_eval,
    input  nclt_pkg::t_idx     i_idx,
    input  logic               i_valid,
    input  nclt_pkg::t_id      i_id,
    input  nclt_pkg::t_tag     i_tag,
    input  nclt_pkg::t_id      i_key,
    output nclt_pkg::t_scan_res o_res
);
    import nclt_pkg::*;

    t_scan_res r_res;
    t_scan_res n_res;
    logic      older;

    // smaller tag wins, equal tags go to the lower identifier
    assign older = (i_tag < r_res.vic_tag) ||
                   ((i_tag == r_res.vic_tag) && (i_id < r_res.vic_id));

    always_comb begin
        n_res = r_res;
        if (i_clear) begin
            n_res.match_found = 1'b0;
            n_res.free_found  = 1'b0;
            n_res.vic_found   = 1'b0;
        end else if (i_eval) begin
            if (i_valid) begin
                if (!r_res.match_found && (i_id == i_key)) begin
                    n_res.match_found = 1'b1;
                    n_res.match_idx   = i_idx;
                end
                if (!r_res.vic_found || older) begin
                    n_res.vic_found = 1'b1;
                    n_res.vic_idx   = i_idx;
                    n_res.vic_tag   = i_tag;
                    n_res.vic_id    = i_id;
                end
            end else if (!r_res.free_found) begin
                n_res.free_found = 1'b1;
                n_res.free_idx   = i_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

>>> sv/node_cache_lru_tags.sv
`timescale 1ns / 1ps

// fully associative node-id cache with lru replacement by timestamp tags.
// a beat is taken when start is high and busy is low; busy then stays high
// while one compare unit walks the entries one per cycle, through the
// registered read of the tag store, a drain state and the write-back, and
// no new beat is taken until the block is back in idle. the result beat
// shows on o_result for exactly one cycle with o_done high, on the cycle
// after the write-back; there is no way to hold it off, so the receiver
// must capture it on that edge.
module node_cache_lru_tags (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  nclt_pkg::t_in_item  i_item,
    output logic                busy,
    output logic                o_done,
    output nclt_pkg::t_out_item o_result
);
    import nclt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_WRITE = 4'b1000
    } t_state;

    t_state    r_state, n_state;
    t_idx      r_idx;              // read address issued this cycle
    t_idx      r_didx;             // index of the data coming out of the store
    logic      r_dvld;             // store read data is due for the compare unit
    logic      r_dbit;             // valid bit that goes with the read data
    logic [CACHE_ENTRIES-1:0] r_valid;
    t_tag      r_counter;
    t_in_item  r_item;
    logic      r_done;
    t_out_item r_result;

    logic      accept;
    logic      last_idx;
    t_id       rd_id;
    t_tag      rd_tag;
    t_scan_res scan;
    t_idx      target;
    t_out_item n_result;

    assign accept   = start && (r_state == ST_IDLE);
    assign last_idx = (r_idx == IDX_W'(CACHE_ENTRIES - 1));

    // sequencer: issue one read address per cycle, drain, then write back
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (start) n_state = ST_SCAN;
            ST_SCAN:  if (last_idx) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_WRITE;
            ST_WRITE: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dvld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dvld  <= (r_state == ST_SCAN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
            r_idx  <= '0;
        end else if (r_state == ST_SCAN && !last_idx) begin
            r_idx <= r_idx + 1'b1;
        end
        r_didx <= r_idx;
        r_dbit <= r_valid[r_idx];
    end

    nclt_store u_store (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_WRITE),
        .i_waddr (target),
        .i_wid   (r_item.node_id),
        .i_wtag  (r_counter),
        .i_raddr (r_idx),
        .o_rid   (rd_id),
        .o_rtag  (rd_tag)
    );

    nclt_scan u_scan (
        .i_clk   (i_clk),
        .i_clear (accept),
        .i_eval  (r_dvld),
        .i_idx   (r_didx),
        .i_valid (r_dbit),
        .i_id    (rd_id),
        .i_tag   (rd_tag),
        .i_key   (r_item.node_id),
        .o_res   (scan)
    );

    // pick the slot: match first, then lowest free slot, else the lru victim
    always_comb begin
        n_result            = '0;
        n_result.hit        = 1'b0;
        n_result.evicted    = 1'b0;
        n_result.evicted_id = '0;
        if (scan.match_found) begin
            target       = scan.match_idx;
            n_result.hit = (r_item.opcode == OP_LOOKUP);
        end else if (scan.free_found) begin
            target = scan.free_idx;
        end else begin
            target              = scan.vic_idx;
            n_result.evicted    = 1'b1;
            n_result.evicted_id = scan.vic_id;
        end
        n_result.slot = SLOT_W'(target);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_counter <= '0;
            r_done    <= 1'b0;
        end else begin
            r_done <= (r_state == ST_WRITE);
            if (r_state == ST_WRITE) begin
                r_valid[target] <= 1'b1;
                r_counter       <= r_counter + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WRITE) begin
            r_result <= n_result;
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

>>> verif/tb_node_cache_lru_tags.sv
`timescale 1ns / 1ps

module tb_node_cache_lru_tags;

    import nclt_pkg::*;

    // cycles with no beat in either direction before the run is declared hung;
    // it sits well above the time of one access plus the longest sender gap
    localparam int STALL_LIMIT  = 2000;
    // settling time after the last result
    localparam int DRAIN_CYCLES = 60;
    localparam int POOL_SIZE    = 48;
    localparam int PHASES       = 12;
    localparam int PHASE_BEATS  = 100;

    // shadow copy of the cache: slot contents, timestamps and the running stamp,
    // plus the outcomes still owed by the block
    class cache_ledger;
        bit        slot_valid [CACHE_ENTRIES];
        t_id       slot_id    [CACHE_ENTRIES];
        t_tag      slot_tag   [CACHE_ENTRIES];
        t_tag      stamp;
        t_out_item owed_outcomes [$];
        int        mismatch_count;

        function new();
            foreach (slot_valid[i]) begin
                slot_valid[i] = 1'b0;
                slot_id[i]    = '0;
                slot_tag[i]   = '0;
            end
            stamp          = '0;
            mismatch_count = 0;
        endfunction

        // work out what an accepted access does to the cache and queue its outcome
        function void note_access(t_in_item acc);
            int        match_idx;
            int        free_idx;
            int        victim_idx;
            int        target;
            t_out_item res;
            match_idx  = -1;
            free_idx   = -1;
            victim_idx = -1;
            for (int i = 0; i < CACHE_ENTRIES; i++) begin
                if (slot_valid[i]) begin
                    if (slot_id[i] == acc.node_id && match_idx < 0)
                        match_idx = i;
                    // oldest stamp loses; equal stamps go to the lower identifier
                    if (victim_idx < 0 || slot_tag[i] < slot_tag[victim_idx] ||
                        (slot_tag[i] == slot_tag[victim_idx] &&
                         slot_id[i] < slot_id[victim_idx]))
                        victim_idx = i;
                end else if (free_idx < 0) begin
                    free_idx = i;
                end
            end
            res = '0;
            if (match_idx >= 0) begin
                // a create of a cached id reuses the slot but is not a hit
                target  = match_idx;
                res.hit = (acc.opcode == OP_LOOKUP);
            end else if (free_idx >= 0) begin
                target = free_idx;
            end else begin
                target         = victim_idx;
                res.evicted    = 1'b1;
                res.evicted_id = slot_id[victim_idx];
            end
            slot_valid[target] = 1'b1;
            slot_id[target]    = acc.node_id;
            slot_tag[target]   = stamp;
            stamp              = stamp + 1'b1;
            res.slot           = target[SLOT_W-1:0];
            owed_outcomes.push_back(res);
        endfunction

        function void check_outcome(t_out_item got);
            t_out_item want;
            if (owed_outcomes.size() == 0) begin
                $error("result beat with no access outstanding: %p", got);
                mismatch_count++;
                return;
            end
            want = owed_outcomes.pop_front();
            if (got.hit !== want.hit) begin
                $error("hit: expected %0b, got %0b", want.hit, got.hit);
                mismatch_count++;
            end
            if (got.evicted !== want.evicted) begin
                $error("evicted: expected %0b, got %0b", want.evicted, got.evicted);
                mismatch_count++;
            end
            if (got.evicted_id !== want.evicted_id) begin
                $error("evicted_id: expected %08h, got %08h",
                       want.evicted_id, got.evicted_id);
                mismatch_count++;
            end
            if (got.slot !== want.slot) begin
                $error("slot: expected %0d, got %0d", want.slot, got.slot);
                mismatch_count++;
            end
        endfunction

        function int outstanding();
            return owed_outcomes.size();
        endfunction
    endclass

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_item  = '0;
    logic      busy;
    logic      o_done;
    t_out_item o_result;

    cache_ledger board;
    t_id         id_pool [POOL_SIZE];
    int          idle_cycles = 0;

    node_cache_lru_tags dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // monitor: a request beat is taken on an edge with start high and busy low,
    // a result beat on any edge with o_done high; both are sampled before this
    // edge's updates land
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                board.check_outcome(o_result);
            if (start && !busy)
                board.note_access(i_item);
        end
    end

    // watchdog on the cycles in which no beat moves either way
    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (start && !busy)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // sender gap: mostly none or short, now and then a long pause
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // random access: ids mostly from a small working set so hits and evictions
    // are common, sometimes a fresh full-width id
    function automatic t_in_item pick_access(int pool_n);
        t_in_item acc;
        acc.opcode = ($urandom_range(0, 3) == 0) ? OP_CREATE : OP_LOOKUP;
        if ($urandom_range(0, 9) == 0)
            acc.node_id = $urandom;
        else
            acc.node_id = id_pool[$urandom_range(0, pool_n - 1)];
        return acc;
    endfunction

    // hold start low for the gap, then present the beat until it is taken;
    // when the gap is zero the next beat follows straight on without start
    // dropping, so start only ever gets one update per edge
    task automatic send_access(input logic op, input t_id id, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_item.opcode  <= op;
        i_item.node_id <= id;
        do @(posedge i_clk); while (busy);
    endtask

    initial begin
        t_in_item acc;
        int       pool_n;
        bit       no_idle;
        board = new();
        foreach (id_pool[i])
            id_pool[i] = $urandom;
        id_pool[0] = '0;
        id_pool[1] = '1;

        // synchronous reset, held low and then released
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme ids, both opcodes, hit on lookup, create of an id
        // already cached, filling of free slots in order, then evictions
        send_access(OP_LOOKUP, 32'h0000_0000, 0);
        send_access(OP_LOOKUP, 32'h0000_0000, pick_gap());
        send_access(OP_CREATE, 32'hFFFF_FFFF, pick_gap());
        send_access(OP_CREATE, 32'hFFFF_FFFF, pick_gap());
        send_access(OP_LOOKUP, 32'hFFFF_FFFF, pick_gap());
        for (int i = 0; i < CACHE_ENTRIES - 2; i++)
            send_access((i % 2 == 0) ? OP_CREATE : OP_LOOKUP,
                        32'h8000_0000 + i, pick_gap());
        send_access(OP_LOOKUP, 32'h5555_5555, pick_gap());
        send_access(OP_CREATE, 32'hAAAA_AAAA, pick_gap());
        send_access(OP_LOOKUP, 32'h0000_0000, pick_gap());
        send_access(OP_LOOKUP, 32'hFFFF_FFFF, pick_gap());
        send_access(OP_CREATE, 32'h8000_0003, pick_gap());

        // random phases with working sets above and below the cache size
        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0: pool_n = 8;
                1: pool_n = CACHE_ENTRIES;
                2: pool_n = CACHE_ENTRIES + 4;
                default: pool_n = POOL_SIZE;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                acc = pick_access(pool_n);
                send_access(acc.opcode, acc.node_id, no_idle ? 0 : pick_gap());
            end
            // halfway through, let the block drain completely before carrying on;
            // one edge first so the monitor has logged the last accepted beat
            if (ph == PHASES / 2) begin
                start <= 1'b0;
                @(posedge i_clk);
                while (board.outstanding() != 0) @(posedge i_clk);
            end
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.mismatch_count == 0 && board.outstanding() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
